### rtl/bba_pkg.sv
// Package for the binary buddy allocator: types, codes, sizes and the
// block index function. Used by bba_core and binary_buddy_allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  localparam int MAX_LEVELS = 10;
  localparam int NBLK       = (1 << MAX_LEVELS) - 1;
  localparam int LVL_W      = 4;
  localparam int BLK_W      = MAX_LEVELS;
  localparam int GIDX_W     = MAX_LEVELS;
  localparam int MEM_DEPTH  = 1 << GIDX_W;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_FREE  = 2'd1;
  localparam logic [1:0] ST_SPLIT = 2'd2;
  localparam logic [1:0] ST_ALLOC = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOMEM   = 2'd1;
  localparam logic [1:0] STAT_ALIGN   = 2'd2;
  localparam logic [1:0] STAT_BADFREE = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] CFG_LEVEL_COUNT = 2'd0;
  localparam logic [1:0] CFG_MIN_BLOCK   = 2'd1;

  typedef struct packed {
    logic        req_type;
    logic [47:0] req_size;
    logic [5:0]  alignment_log2;
    logic [47:0] free_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] alloc_offset;
  } res_t;

  typedef struct packed {
    logic [LVL_W-1:0] lc;
    logic [5:0]       m;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] blk;
  } link_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LVL, S_DISP,
    S_SP_RD, S_SP_POP, S_SP_W1, S_SP_W2, S_AL_RD, S_AL_POP,
    S_F_CHK, S_F_TST, S_F_LOOP, S_F_BTST, S_RM, S_RM_POP, S_RM_CHK,
    S_RM_LINK, S_MERGE, S_F_PUSH
  } state_t;

  function automatic logic [GIDX_W-1:0] gidx(input logic [LVL_W-1:0] lc,
                                             input logic [LVL_W-1:0] lvl,
                                             input logic [BLK_W-1:0] b);
    logic [11:0]      t;
    logic [LVL_W-1:0] d;
    d = (lvl < lc) ? lc - lvl : '0;
    t = (12'd1 << lc) - (12'd1 << d) + {2'b00, b};
    return (t < 12'(NBLK)) ? t[GIDX_W-1:0] : '0;
  endfunction

endpackage
`default_nettype wire

### rtl/bba_ram.sv
// Generic single write port, single read port synchronous RAM.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/bba_core.sv
// Allocator sequencer: block state and free list link memories, list heads,
// split/merge control. Depends on bba_pkg and bba_ram.
`timescale 1ns / 1ps
`default_nettype none
module bba_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          restart,
  input  wire bba_pkg::cfg_t cfg,
  input  wire logic          start,
  input  wire bba_pkg::req_t req,
  output logic               busy,
  output logic               out_valid,
  output bba_pkg::res_t      out_res
);

  localparam int LW = bba_pkg::LVL_W;
  localparam int BW = bba_pkg::BLK_W;
  localparam int GW = bba_pkg::GIDX_W;

  bba_pkg::state_t state_r, state_nxt;
  bba_pkg::req_t   req_r, req_nxt;
  logic [47:0]     v_r, v_nxt;
  logic [LW-1:0]   lvl_r, lvl_nxt, s_r, s_nxt, lv_r, lv_nxt;
  logic [BW-1:0]   p_r, p_nxt, b_r, b_nxt, idx_r, idx_nxt;
  logic [GW-1:0]   prev_r, prev_nxt, clr_r, clr_nxt;
  logic            big_r, big_nxt;
  logic [BW-1:0]   head_r [bba_pkg::MAX_LEVELS];
  logic [BW-1:0]   head_nxt [bba_pkg::MAX_LEVELS];
  logic [bba_pkg::MAX_LEVELS-1:0] hv_r, hv_nxt;
  logic            out_valid_r, out_valid_nxt;
  bba_pkg::res_t   out_res_r, out_res_nxt;

  logic                bs_we;
  logic [GW-1:0]       bs_waddr, bs_raddr;
  logic [1:0]          bs_wdata, bs_rdata;
  logic                nx_we;
  logic [GW-1:0]       nx_waddr, nx_raddr;
  bba_pkg::link_t      nx_wdata, nx_rdata;

  bba_ram #(.DEPTH(bba_pkg::MEM_DEPTH), .WIDTH(2)) u_bs (
    .clk(clk), .we(bs_we), .waddr(bs_waddr), .wdata(bs_wdata),
    .raddr(bs_raddr), .rdata(bs_rdata)
  );

  bba_ram #(.DEPTH(bba_pkg::MEM_DEPTH), .WIDTH(BW + 1)) u_nx (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  logic [6:0]    sh;
  logic [LW-1:0] found_lvl;
  logic          found;
  logic [47:0]   idx48;
  logic [BW-1:0] bud, p2;
  logic [LW-1:0] sm1, lm1;

  always_comb begin
    sh = {3'b000, lvl_r} + {1'b0, cfg.m};
    found = 1'b0;
    found_lvl = '0;
    for (int k = bba_pkg::MAX_LEVELS - 1; k >= 0; k--) begin
      if (LW'(k) >= lvl_r && LW'(k) < cfg.lc && hv_r[k]) begin
        found = 1'b1;
        found_lvl = LW'(k);
      end
    end
    idx48 = (sh >= 7'd48) ? 48'd0 : (req_r.free_offset >> sh[5:0]);
    bud = b_r ^ BW'(1);
    p2 = {p_r[BW-2:0], 1'b0};
    sm1 = s_r - LW'(1);
    lm1 = cfg.lc - LW'(1);
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    v_nxt = v_r;
    lvl_nxt = lvl_r;
    s_nxt = s_r;
    lv_nxt = lv_r;
    p_nxt = p_r;
    b_nxt = b_r;
    idx_nxt = idx_r;
    prev_nxt = prev_r;
    clr_nxt = clr_r;
    big_nxt = big_r;
    head_nxt = head_r;
    hv_nxt = hv_r;
    out_valid_nxt = 1'b0;
    out_res_nxt = out_res_r;
    bs_we = 1'b0;
    bs_waddr = '0;
    bs_wdata = bba_pkg::ST_NONE;
    bs_raddr = '0;
    nx_we = 1'b0;
    nx_waddr = '0;
    nx_wdata = '0;
    nx_raddr = '0;
    case (state_r)
      bba_pkg::S_CLR: begin
        bs_we = 1'b1;
        bs_waddr = clr_r;
        bs_wdata = (clr_r == bba_pkg::gidx(cfg.lc, lm1, '0)) ? bba_pkg::ST_FREE
                                                              : bba_pkg::ST_NONE;
        nx_we = 1'b1;
        nx_waddr = clr_r;
        clr_nxt = clr_r + GW'(1);
        if (clr_r == GW'(bba_pkg::MEM_DEPTH - 1)) begin
          state_nxt = bba_pkg::S_IDLE;
          hv_nxt = '0;
          hv_nxt[lm1] = 1'b1;
          for (int k = 0; k < bba_pkg::MAX_LEVELS; k++) begin
            head_nxt[k] = '0;
          end
        end
      end
      bba_pkg::S_IDLE: begin
        if (start) begin
          req_nxt = req;
          lvl_nxt = '0;
          if (req.req_size == 48'd0 || cfg.m >= 6'd48) begin
            v_nxt = '0;
          end else begin
            v_nxt = (req.req_size - 48'd1) >> cfg.m;
          end
          state_nxt = bba_pkg::S_LVL;
        end
      end
      bba_pkg::S_LVL: begin
        if (v_r == '0 || lvl_r == LW'(bba_pkg::MAX_LEVELS)) begin
          state_nxt = bba_pkg::S_DISP;
        end else begin
          v_nxt = v_r >> 1;
          lvl_nxt = lvl_r + LW'(1);
        end
      end
      bba_pkg::S_DISP: begin
        if (req_r.req_type == bba_pkg::REQ_ALLOC) begin
          if (lvl_r >= cfg.lc) begin
            out_valid_nxt = 1'b1;
            out_res_nxt = '{status: bba_pkg::STAT_NOMEM, alloc_offset: '0};
            state_nxt = bba_pkg::S_IDLE;
          end else if ({1'b0, req_r.alignment_log2} > sh) begin
            out_valid_nxt = 1'b1;
            out_res_nxt = '{status: bba_pkg::STAT_ALIGN, alloc_offset: '0};
            state_nxt = bba_pkg::S_IDLE;
          end else if (!found) begin
            out_valid_nxt = 1'b1;
            out_res_nxt = '{status: bba_pkg::STAT_NOMEM, alloc_offset: '0};
            state_nxt = bba_pkg::S_IDLE;
          end else if (found_lvl == lvl_r) begin
            state_nxt = bba_pkg::S_AL_RD;
          end else begin
            s_nxt = found_lvl;
            state_nxt = bba_pkg::S_SP_RD;
          end
        end else begin
          if (lvl_r >= cfg.lc) begin
            out_valid_nxt = 1'b1;
            out_res_nxt = '{status: bba_pkg::STAT_BADFREE, alloc_offset: '0};
            state_nxt = bba_pkg::S_IDLE;
          end else begin
            idx_nxt = idx48[BW-1:0];
            big_nxt = (idx48 >> (lm1 - lvl_r)) != 48'd0;
            state_nxt = bba_pkg::S_F_CHK;
          end
        end
      end
      bba_pkg::S_SP_RD: begin
        p_nxt = head_r[s_r];
        nx_raddr = bba_pkg::gidx(cfg.lc, s_r, head_r[s_r]);
        state_nxt = bba_pkg::S_SP_POP;
      end
      bba_pkg::S_SP_POP: begin
        head_nxt[s_r] = nx_rdata.blk;
        hv_nxt[s_r] = nx_rdata.valid;
        bs_we = 1'b1;
        bs_waddr = bba_pkg::gidx(cfg.lc, s_r, p_r);
        bs_wdata = bba_pkg::ST_SPLIT;
        state_nxt = bba_pkg::S_SP_W1;
      end
      bba_pkg::S_SP_W1: begin
        bs_we = 1'b1;
        bs_waddr = bba_pkg::gidx(cfg.lc, sm1, p2);
        bs_wdata = bba_pkg::ST_FREE;
        nx_we = 1'b1;
        nx_waddr = bba_pkg::gidx(cfg.lc, sm1, p2 | BW'(1));
        nx_wdata = '{valid: hv_r[sm1], blk: head_r[sm1]};
        state_nxt = bba_pkg::S_SP_W2;
      end
      bba_pkg::S_SP_W2: begin
        bs_we = 1'b1;
        bs_waddr = bba_pkg::gidx(cfg.lc, sm1, p2 | BW'(1));
        bs_wdata = bba_pkg::ST_FREE;
        nx_we = 1'b1;
        nx_waddr = bba_pkg::gidx(cfg.lc, sm1, p2);
        nx_wdata = '{valid: 1'b1, blk: p2 | BW'(1)};
        head_nxt[sm1] = p2;
        hv_nxt[sm1] = 1'b1;
        s_nxt = sm1;
        state_nxt = (sm1 > lvl_r) ? bba_pkg::S_SP_RD : bba_pkg::S_AL_RD;
      end
      bba_pkg::S_AL_RD: begin
        b_nxt = head_r[lvl_r];
        nx_raddr = bba_pkg::gidx(cfg.lc, lvl_r, head_r[lvl_r]);
        state_nxt = bba_pkg::S_AL_POP;
      end
      bba_pkg::S_AL_POP: begin
        head_nxt[lvl_r] = nx_rdata.blk;
        hv_nxt[lvl_r] = nx_rdata.valid;
        bs_we = 1'b1;
        bs_waddr = bba_pkg::gidx(cfg.lc, lvl_r, b_r);
        bs_wdata = bba_pkg::ST_ALLOC;
        out_valid_nxt = 1'b1;
        out_res_nxt.status = bba_pkg::STAT_OK;
        out_res_nxt.alloc_offset = (sh >= 7'd48) ? 48'd0
                                 : ({{(48 - BW){1'b0}}, b_r} << sh[5:0]);
        state_nxt = bba_pkg::S_IDLE;
      end
      bba_pkg::S_F_CHK: begin
        if (big_r) begin
          out_valid_nxt = 1'b1;
          out_res_nxt = '{status: bba_pkg::STAT_BADFREE, alloc_offset: '0};
          state_nxt = bba_pkg::S_IDLE;
        end else begin
          bs_raddr = bba_pkg::gidx(cfg.lc, lvl_r, idx_r);
          state_nxt = bba_pkg::S_F_TST;
        end
      end
      bba_pkg::S_F_TST: begin
        if (bs_rdata != bba_pkg::ST_ALLOC) begin
          out_valid_nxt = 1'b1;
          out_res_nxt = '{status: bba_pkg::STAT_BADFREE, alloc_offset: '0};
          state_nxt = bba_pkg::S_IDLE;
        end else begin
          bs_we = 1'b1;
          bs_waddr = bba_pkg::gidx(cfg.lc, lvl_r, idx_r);
          bs_wdata = bba_pkg::ST_FREE;
          lv_nxt = lvl_r;
          b_nxt = idx_r;
          state_nxt = bba_pkg::S_F_LOOP;
        end
      end
      bba_pkg::S_F_LOOP: begin
        if (lv_r == lm1) begin
          state_nxt = bba_pkg::S_F_PUSH;
        end else begin
          bs_raddr = bba_pkg::gidx(cfg.lc, lv_r, bud);
          state_nxt = bba_pkg::S_F_BTST;
        end
      end
      bba_pkg::S_F_BTST: begin
        state_nxt = (bs_rdata != bba_pkg::ST_FREE) ? bba_pkg::S_F_PUSH : bba_pkg::S_RM;
      end
      bba_pkg::S_RM: begin
        if (!hv_r[lv_r]) begin
          state_nxt = bba_pkg::S_MERGE;
        end else if (head_r[lv_r] == bud) begin
          nx_raddr = bba_pkg::gidx(cfg.lc, lv_r, bud);
          state_nxt = bba_pkg::S_RM_POP;
        end else begin
          nx_raddr = bba_pkg::gidx(cfg.lc, lv_r, head_r[lv_r]);
          prev_nxt = bba_pkg::gidx(cfg.lc, lv_r, head_r[lv_r]);
          state_nxt = bba_pkg::S_RM_CHK;
        end
      end
      bba_pkg::S_RM_POP: begin
        head_nxt[lv_r] = nx_rdata.blk;
        hv_nxt[lv_r] = nx_rdata.valid;
        state_nxt = bba_pkg::S_MERGE;
      end
      bba_pkg::S_RM_CHK: begin
        // nx_rdata is the link out of prev_r
        if (!nx_rdata.valid) begin
          state_nxt = bba_pkg::S_MERGE;
        end else begin
          nx_raddr = bba_pkg::gidx(cfg.lc, lv_r, nx_rdata.blk);
          if (nx_rdata.blk == bud) begin
            state_nxt = bba_pkg::S_RM_LINK;
          end else begin
            prev_nxt = bba_pkg::gidx(cfg.lc, lv_r, nx_rdata.blk);
          end
        end
      end
      bba_pkg::S_RM_LINK: begin
        nx_we = 1'b1;
        nx_waddr = prev_r;
        nx_wdata = nx_rdata;
        state_nxt = bba_pkg::S_MERGE;
      end
      bba_pkg::S_MERGE: begin
        lv_nxt = lv_r + LW'(1);
        b_nxt = b_r >> 1;
        bs_we = 1'b1;
        bs_waddr = bba_pkg::gidx(cfg.lc, lv_r + LW'(1), b_r >> 1);
        bs_wdata = bba_pkg::ST_FREE;
        state_nxt = bba_pkg::S_F_LOOP;
      end
      bba_pkg::S_F_PUSH: begin
        nx_we = 1'b1;
        nx_waddr = bba_pkg::gidx(cfg.lc, lv_r, b_r);
        nx_wdata = '{valid: hv_r[lv_r], blk: head_r[lv_r]};
        head_nxt[lv_r] = b_r;
        hv_nxt[lv_r] = 1'b1;
        out_valid_nxt = 1'b1;
        out_res_nxt = '{status: bba_pkg::STAT_OK, alloc_offset: '0};
        state_nxt = bba_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bba_pkg::S_CLR;
        clr_nxt = '0;
      end
    endcase
    if (restart) begin
      state_nxt = bba_pkg::S_CLR;
      clr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_CLR;
      clr_r <= '0;
      hv_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      hv_r <= hv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    v_r <= v_nxt;
    lvl_r <= lvl_nxt;
    s_r <= s_nxt;
    lv_r <= lv_nxt;
    p_r <= p_nxt;
    b_r <= b_nxt;
    idx_r <= idx_nxt;
    prev_r <= prev_nxt;
    big_r <= big_nxt;
    head_r <= head_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy = (state_r != bba_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res = out_res_r;

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("back-to-back results");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted item did not start");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy) else $error("result while busy");
`endif

endmodule
`default_nettype wire

### rtl/binary_buddy_allocator.sv
// Binary buddy allocator top level: configuration registers and sequencer.
// Depends on bba_pkg and bba_core.
//
// A request is taken when start is high and busy is low; its single result
// appears on out_res for one cycle with out_valid, and must be taken then.
// An item is classified by reducing its size to a level L, at most 10. An
// allocate then splits a larger free block one level at a time and pops its
// block; a free checks its block, merges it with free buddies level by
// level, walking each buddy's free list to unlink it, and pushes the result.
// After reset and after a write to the level count or minimum block register
// the block is busy while it clears its memory. Each memory has one read port.
`timescale 1ns / 1ps
`default_nettype none
module binary_buddy_allocator (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire bba_pkg::req_t in_req,
  output logic               busy,
  output logic               out_valid,
  output bba_pkg::res_t      out_res,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [5:0]    cfg_wdata
);

  logic [3:0] level_count_r, level_count_nxt;
  logic [5:0] min_block_r, min_block_nxt;
  logic       restart;
  bba_pkg::cfg_t cfg;

  always_comb begin
    level_count_nxt = level_count_r;
    min_block_nxt = min_block_r;
    restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        bba_pkg::CFG_LEVEL_COUNT: begin
          level_count_nxt = cfg_wdata[3:0];
          restart = 1'b1;
        end
        bba_pkg::CFG_MIN_BLOCK: begin
          min_block_nxt = cfg_wdata;
          restart = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (level_count_r == 4'd0) begin
      cfg.lc = bba_pkg::LVL_W'(1);
    end else if (level_count_r > 4'(bba_pkg::MAX_LEVELS)) begin
      cfg.lc = bba_pkg::LVL_W'(bba_pkg::MAX_LEVELS);
    end else begin
      cfg.lc = level_count_r;
    end
    cfg.m = min_block_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= 4'd10;
      min_block_r <= 6'd8;
    end else begin
      level_count_r <= level_count_nxt;
      min_block_r <= min_block_nxt;
    end
  end

  bba_core u_core (
    .clk(clk), .rst_n(rst_n), .restart(restart), .cfg(cfg),
    .start(start), .req(in_req), .busy(busy),
    .out_valid(out_valid), .out_res(out_res)
  );

endmodule
`default_nettype wire
